// File: sv/nalsp_pkg.sv
// ============================================================================
// nalsp_pkg: shared types and constants for the annex b nal unit splitter
// holds the transaction structs, scan mode encoding, codes and defaults
// ============================================================================
package nalsp_pkg;

  // default widths for the internal counters
  localparam int LENGTH_BITS_DEF = 24;
  localparam int OFFSET_BITS_DEF = 32;

  // field widths
  localparam int LEN_FIELD_BITS = 24;
  localparam int IDX_FIELD_BITS = 32;
  localparam int OFF_FIELD_BITS = 32;

  // configuration port
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_WORD_LSB  = 2;
  localparam logic [CFG_ADDR_BITS-1-CFG_WORD_LSB:0] REG_MAX_NAL_BYTES = 1'b0;
  localparam logic [LEN_FIELD_BITS-1:0] MAX_NAL_BYTES_RST = 24'd131072;

  // input action codes
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_EOS  = 1'b1;

  // result status codes
  localparam logic ST_UNIT      = 1'b0;
  localparam logic ST_NO_PREFIX = 1'b1;

  // start code bytes and lengths
  localparam logic [7:0]  SC_ONE       = 8'h01;
  localparam logic [23:0] SC_THREE     = 24'h000001;
  localparam logic [23:0] RECENT_RST   = 24'hffffff;
  localparam logic [2:0]  PFX_LEN3     = 3'd3;
  localparam logic [2:0]  PFX_LEN4     = 3'd4;
  localparam logic [2:0]  PFX_NONE     = 3'd0;

  // nal header byte fields
  localparam logic [7:0] HDR_FORBIDDEN_MASK = 8'h80;
  localparam logic [7:0] HDR_REF_IDC_MASK   = 8'h60;
  localparam logic [7:0] HDR_TYPE_MASK      = 8'h1f;

  typedef enum logic [1:0] {
    MODE_SEARCH = 2'b01,
    MODE_UNIT   = 2'b10
  } scan_mode_t;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic                      status;
    logic [IDX_FIELD_BITS-1:0] unit_index;
    logic [OFF_FIELD_BITS-1:0] unit_offset;
    logic [2:0]                prefix_length;
    logic                      forbidden_zero;
    logic [1:0]                reference_idc;
    logic [4:0]                unit_type;
    logic [LEN_FIELD_BITS-1:0] payload_length;
    logic                      length_overflow;
  } out_item_t;

endpackage

// File: sv/annexb_nal_unit_splitter_top.sv
// ============================================================================
// annexb_nal_unit_splitter_top: annex b start code scanner and nal splitter
// takes a byte stream, finds 3 and 4 byte start codes, emits one record per
// nal unit (or a no-prefix error record) with header fields and length
// ============================================================================
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------
//  in      | input     | in_valid / in_stall    | in_data  (in_item_t)
//  out     | output    | out_valid / out_stall  | out_data (out_item_t)
//  cfg     | input     | psel/penable/pwrite    | paddr, pwdata, prdata
//
//  one input transaction per cycle while in_stall is low; the window compare,
//  saturating length counter and record build all sit combinationally between
//  the scan state registers and the output register (or the skid register
//  while the output is stalled); a two-entry output path (output register
//  plus skid register) keeps accepting bytes while a record waits; in_stall
//  rises only when both hold a record
//  rst_n is synchronous and active low; max_nal_bytes returns to 131072
//  an end-of-stream transaction returns all scan state to reset values
//
module annexb_nal_unit_splitter_top #(
  parameter int LENGTH_BITS = nalsp_pkg::LENGTH_BITS_DEF,
  parameter int OFFSET_BITS = nalsp_pkg::OFFSET_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input byte channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  nalsp_pkg::in_item_t                   in_data,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output nalsp_pkg::out_item_t                  out_data,
  // configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [nalsp_pkg::CFG_ADDR_BITS-1:0]   paddr,
  input  logic [nalsp_pkg::CFG_DATA_BITS-1:0]   pwdata,
  output logic [nalsp_pkg::CFG_DATA_BITS-1:0]   prdata,
  output logic                                  pready
);

  localparam int LFB      = nalsp_pkg::LEN_FIELD_BITS;
  // compare width covers both the counter and the limit register
  localparam int CMP_BITS = (LENGTH_BITS > LFB) ? LENGTH_BITS : LFB;
  localparam logic [LENGTH_BITS-1:0] CNT_MAX = {LENGTH_BITS{1'b1}};

  // --------------------------------------------------------------------------
  // configuration register
  // --------------------------------------------------------------------------
  logic [LFB-1:0] max_nal_r;
  logic           cfg_wr;
  logic           cfg_hit;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[nalsp_pkg::CFG_ADDR_BITS-1:nalsp_pkg::CFG_WORD_LSB]
                    == nalsp_pkg::REG_MAX_NAL_BYTES);
  assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_nal_r <= nalsp_pkg::MAX_NAL_BYTES_RST;
    end else if (cfg_wr) begin
      max_nal_r <= pwdata[LFB-1:0];
    end
  end

  // read back, upper bits zero
  assign prdata = cfg_hit ? nalsp_pkg::CFG_DATA_BITS'(max_nal_r) : '0;

  // --------------------------------------------------------------------------
  // scan state
  // --------------------------------------------------------------------------
  nalsp_pkg::scan_mode_t   mode_r, mode_nxt;
  logic [2:0]              pbs_r, pbs_nxt;          // prefix bytes seen
  logic [23:0]             recent_r, recent_nxt;    // last three bytes
  logic [LENGTH_BITS-1:0]  cnt_r, cnt_nxt;          // payload byte count
  logic [7:0]              hdr_r, hdr_nxt;          // first payload byte
  logic [2:0]              prefix_r, prefix_nxt;    // current start code length
  logic [OFFSET_BITS-1:0]  offset_r, offset_nxt;    // stream byte offset
  logic [OFFSET_BITS-1:0]  start_r, start_nxt;      // offset of unit start code
  logic [nalsp_pkg::IDX_FIELD_BITS-1:0] rec_cnt_r, rec_cnt_nxt;

  logic                    skid_valid_r;
  logic                    in_acc;

  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !in_stall;

  // per-byte decode
  logic [2:0]              pbs_inc;
  logic [LENGTH_BITS-1:0]  cnt_inc;
  logic [7:0]              hdr_cur;
  logic [2:0]              code_len;

  // record request
  logic                    unit_emit;
  logic                    err_emit;
  logic [LENGTH_BITS-1:0]  len_raw;
  logic                    len_sat;
  logic [7:0]              hb_src;

  always_comb begin
    mode_nxt    = mode_r;
    pbs_nxt     = pbs_r;
    recent_nxt  = recent_r;
    cnt_nxt     = cnt_r;
    hdr_nxt     = hdr_r;
    prefix_nxt  = prefix_r;
    offset_nxt  = offset_r;
    start_nxt   = start_r;
    unit_emit   = 1'b0;
    err_emit    = 1'b0;
    len_raw     = '0;
    len_sat     = 1'b0;
    hb_src      = hdr_r;

    pbs_inc  = pbs_r + 3'd1;
    cnt_inc  = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 1'b1;
    hdr_cur  = (cnt_r == '0) ? in_data.data_byte : hdr_r;
    // four byte code wins over three byte code
    if (recent_r == '0 && in_data.data_byte == nalsp_pkg::SC_ONE) begin
      code_len = nalsp_pkg::PFX_LEN4;
    end else if (recent_r[15:0] == '0 && in_data.data_byte == nalsp_pkg::SC_ONE) begin
      code_len = nalsp_pkg::PFX_LEN3;
    end else begin
      code_len = nalsp_pkg::PFX_NONE;
    end

    if (in_acc) begin
      if (in_data.action == nalsp_pkg::ACT_EOS) begin
        // flush the unit in progress, then back to reset state
        if (mode_r == nalsp_pkg::MODE_UNIT) begin
          unit_emit = 1'b1;
          len_raw   = cnt_r;
          len_sat   = (cnt_r == CNT_MAX);
        end
        mode_nxt   = nalsp_pkg::MODE_SEARCH;
        pbs_nxt    = '0;
        recent_nxt = nalsp_pkg::RECENT_RST;
        cnt_nxt    = '0;
        hdr_nxt    = '0;
        prefix_nxt = nalsp_pkg::PFX_LEN3;
        offset_nxt = '0;
        start_nxt  = '0;
      end else begin
        recent_nxt = {recent_r[15:0], in_data.data_byte};
        offset_nxt = offset_r + 1'b1;
        case (mode_r)
          nalsp_pkg::MODE_SEARCH: begin
            if (pbs_r == '0) begin
              start_nxt = offset_r;
            end
            pbs_nxt = pbs_inc;
            if (pbs_inc == 3'd3 && recent_nxt == nalsp_pkg::SC_THREE) begin
              mode_nxt   = nalsp_pkg::MODE_UNIT;
              prefix_nxt = nalsp_pkg::PFX_LEN3;
              pbs_nxt    = '0;
              cnt_nxt    = '0;
              hdr_nxt    = '0;
            end else if (pbs_inc >= 3'd4) begin
              if (code_len == nalsp_pkg::PFX_LEN4) begin
                mode_nxt   = nalsp_pkg::MODE_UNIT;
                prefix_nxt = nalsp_pkg::PFX_LEN4;
                cnt_nxt    = '0;
                hdr_nxt    = '0;
              end else begin
                err_emit = 1'b1;
              end
              pbs_nxt = '0;
            end
          end
          nalsp_pkg::MODE_UNIT: begin
            if (code_len != nalsp_pkg::PFX_NONE) begin
              // the new start code closes this unit and opens the next
              unit_emit = 1'b1;
              len_sat   = (cnt_inc == CNT_MAX);
              if (len_sat) begin
                len_raw = CNT_MAX;
              end else if (cnt_inc >= LENGTH_BITS'(code_len)) begin
                len_raw = cnt_inc - LENGTH_BITS'(code_len);
              end else begin
                len_raw = '0;
              end
              hb_src     = hdr_cur;
              start_nxt  = offset_r - OFFSET_BITS'(code_len - 3'd1);
              prefix_nxt = code_len;
              cnt_nxt    = '0;
              hdr_nxt    = '0;
            end else begin
              cnt_nxt = cnt_inc;
              hdr_nxt = hdr_cur;
            end
          end
          default: begin
            mode_nxt = nalsp_pkg::MODE_SEARCH;
          end
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // record build
  // --------------------------------------------------------------------------
  logic [CMP_BITS-1:0]  len_ext;
  logic [CMP_BITS-1:0]  max_ext;
  logic                 len_over;
  logic [7:0]           hb;
  logic [63:0]          start_ext;
  nalsp_pkg::out_item_t rec;
  logic                 rec_valid;

  assign len_ext   = CMP_BITS'(len_raw);
  assign max_ext   = CMP_BITS'(max_nal_r);
  assign len_over  = (len_ext > max_ext);
  assign hb        = (len_raw == '0) ? 8'h00 : hb_src;
  assign start_ext = 64'(start_r);
  assign rec_valid = unit_emit || err_emit;

  always_comb begin
    rec             = '0;
    rec.unit_index  = rec_cnt_r;
    rec.unit_offset = start_ext[nalsp_pkg::OFF_FIELD_BITS-1:0];
    if (err_emit) begin
      rec.status = nalsp_pkg::ST_NO_PREFIX;
    end else begin
      rec.status          = nalsp_pkg::ST_UNIT;
      rec.prefix_length   = prefix_r;
      rec.forbidden_zero  = |(hb & nalsp_pkg::HDR_FORBIDDEN_MASK);
      rec.reference_idc   = hb[6:5] & nalsp_pkg::HDR_REF_IDC_MASK[6:5];
      rec.unit_type       = hb[4:0] & nalsp_pkg::HDR_TYPE_MASK[4:0];
      // saturated length is below the 24 bit limit, truncation is exact
      rec.payload_length  = len_over ? max_nal_r : len_ext[LFB-1:0];
      rec.length_overflow = len_sat || len_over;
    end
  end

  // index counts every record; end of stream restarts it
  always_comb begin
    rec_cnt_nxt = rec_cnt_r;
    if (in_acc && in_data.action == nalsp_pkg::ACT_EOS) begin
      rec_cnt_nxt = '0;
    end else if (rec_valid) begin
      rec_cnt_nxt = rec_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= nalsp_pkg::MODE_SEARCH;
      pbs_r     <= '0;
      recent_r  <= nalsp_pkg::RECENT_RST;
      cnt_r     <= '0;
      hdr_r     <= '0;
      prefix_r  <= nalsp_pkg::PFX_LEN3;
      offset_r  <= '0;
      start_r   <= '0;
      rec_cnt_r <= '0;
    end else begin
      mode_r    <= mode_nxt;
      pbs_r     <= pbs_nxt;
      recent_r  <= recent_nxt;
      cnt_r     <= cnt_nxt;
      hdr_r     <= hdr_nxt;
      prefix_r  <= prefix_nxt;
      offset_r  <= offset_nxt;
      start_r   <= start_nxt;
      rec_cnt_r <= rec_cnt_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // output register with skid stage
  // --------------------------------------------------------------------------
  logic                 out_valid_r;
  nalsp_pkg::out_item_t out_data_r;
  nalsp_pkg::out_item_t skid_data_r;
  logic                 out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        // no transaction accepted while the skid holds a record
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= rec_valid;
      end
    end else if (rec_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data_r <= skid_valid_r ? skid_data_r : rec;
    end
    if (!out_free && rec_valid) begin
      skid_data_r <= rec;
    end
  end

`ifndef SYNTHESIS
  // the skid only fills behind a held output record
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a record while output register is empty");

  // unit records carry a three or four byte prefix length
  a_unit_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status == nalsp_pkg::ST_UNIT) |->
      (out_data_r.prefix_length == nalsp_pkg::PFX_LEN3 ||
       out_data_r.prefix_length == nalsp_pkg::PFX_LEN4))
    else $error("unit record with bad prefix length");

  // the prefix search never runs past four bytes
  a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pbs_r < 3'd4)
    else $error("prefix byte count out of range");

  // end of stream restarts offset and record index
  a_eos_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.action == nalsp_pkg::ACT_EOS) |=>
      (offset_r == '0 && rec_cnt_r == '0 && mode_r == nalsp_pkg::MODE_SEARCH))
    else $error("state not restarted after end of stream");
`endif

endmodule
